>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tkl_pkg.sv
// shared types and constants for the top-k score list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tkl_pkg;
	localparam int LIST_SIZE_DEF = 16;
	localparam int DOC_BITS_DEF  = 16;

	localparam int DOC_W   = 16;
	localparam int SCORE_W = 32;
	localparam int SLOT_W  = 4;
	localparam int IN_W    = 56;
	localparam int OUT_W   = 72;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} tkl_state_t;

	// input item, lowest field last
	typedef struct packed {
		logic [3:0]                pad;
		logic [SLOT_W-1:0]         slot;
		logic signed [SCORE_W-1:0] score;
		logic [DOC_W-1:0]          doc_id;
	} tkl_in_t;

	// result item, lowest field last
	typedef struct packed {
		logic [4:0]                pad;
		logic [DOC_W-1:0]          dropped_doc;
		logic                      dropped_valid;
		logic                      was_present;
		logic signed [SCORE_W-1:0] slot_score;
		logic [DOC_W-1:0]          slot_doc;
		logic                      slot_valid;
	} tkl_out_t;

	// controls from the sequencer to the cell row
	typedef struct packed {
		logic match_en;
		logic inject;
	} tkl_walk_ctl_t;
endpackage
`default_nettype wire

>>> rtl/tkl_cell.sv
// one slot of the top-k list: holds an entry and passes the carried entry on
// depends on tkl_pkg
`timescale 1ns / 1ps
`default_nettype none
module tkl_cell #(
	parameter int DOC_BITS = tkl_pkg::DOC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              match_en,
	input  wire logic [DOC_BITS-1:0]               match_doc,
	input  wire logic                              carry_in_valid,
	input  wire logic [DOC_BITS-1:0]               carry_in_doc,
	input  wire logic signed [tkl_pkg::SCORE_W-1:0] carry_in_score,
	output logic                                   carry_out_valid,
	output logic [DOC_BITS-1:0]                    carry_out_doc,
	output logic signed [tkl_pkg::SCORE_W-1:0]     carry_out_score,
	output logic                                   hit,
	output logic                                   entry_valid,
	output logic [DOC_BITS-1:0]                    entry_doc,
	output logic signed [tkl_pkg::SCORE_W-1:0]     entry_score
);
	import tkl_pkg::*;

	logic                      valid_q;
	logic [DOC_BITS-1:0]       doc_q;
	logic signed [SCORE_W-1:0] score_q;
	logic                      cvalid_q;
	logic [DOC_BITS-1:0]       cdoc_q;
	logic signed [SCORE_W-1:0] cscore_q;
	logic                      below;
	logic                      take;

	assign hit   = match_en && valid_q && (doc_q == match_doc);
	assign below = score_q < carry_in_score;
	// empty slot takes the carry and stops it, a weaker entry trades places
	assign take  = carry_in_valid && (!valid_q || below);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			cvalid_q <= 1'b0;
		end else begin
			if (hit) begin
				valid_q <= 1'b0;
			end else if (carry_in_valid && !valid_q) begin
				valid_q <= 1'b1;
			end
			cvalid_q <= carry_in_valid && valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			doc_q   <= carry_in_doc;
			score_q <= carry_in_score;
		end
		if (below) begin
			cdoc_q   <= doc_q;
			cscore_q <= score_q;
		end else begin
			cdoc_q   <= carry_in_doc;
			cscore_q <= carry_in_score;
		end
	end

	assign carry_out_valid = cvalid_q;
	assign carry_out_doc   = cdoc_q;
	assign carry_out_score = cscore_q;
	assign entry_valid     = valid_q;
	assign entry_doc       = doc_q;
	assign entry_score     = score_q;
endmodule
`default_nettype wire

>>> rtl/tkl_ctrl.sv
// sequencer of the top-k list: input handshake, walk counter, result register
// depends on tkl_pkg
`timescale 1ns / 1ps
`default_nettype none
module tkl_ctrl #(
	parameter int LIST_SIZE = tkl_pkg::LIST_SIZE_DEF,
	parameter int DOC_BITS  = tkl_pkg::DOC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic                               mode,
	input  wire logic [DOC_BITS-1:0]                in_doc,
	input  wire logic signed [tkl_pkg::SCORE_W-1:0] in_score,
	input  wire logic [tkl_pkg::SLOT_W-1:0]         in_slot,
	output tkl_pkg::tkl_walk_ctl_t                  walk_ctl,
	output logic [DOC_BITS-1:0]                     inj_doc,
	output logic signed [tkl_pkg::SCORE_W-1:0]      inj_score,
	input  wire logic                               hit_any,
	output logic [tkl_pkg::SLOT_W-1:0]              slot_sel,
	input  wire logic                               rd_valid,
	input  wire logic [DOC_BITS-1:0]                rd_doc,
	input  wire logic signed [tkl_pkg::SCORE_W-1:0] rd_score,
	input  wire logic                               last_valid,
	input  wire logic [DOC_BITS-1:0]                last_doc,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [tkl_pkg::OUT_W-1:0]               m_tdata
);
	import tkl_pkg::*;

	localparam int CNT_W = $clog2(LIST_SIZE + 1);

	tkl_state_t                state_q, state_d;
	logic [CNT_W-1:0]          cnt_q;
	logic                      mode_q;
	logic [SLOT_W-1:0]         slot_q;
	logic                      present_q;
	logic                      inj_q;
	logic [DOC_BITS-1:0]       inj_doc_q;
	logic signed [SCORE_W-1:0] inj_score_q;
	logic                      drop_v_q;
	logic [DOC_BITS-1:0]       drop_doc_q;
	logic                      m_tvalid_q;
	tkl_out_t                  m_tdata_q;
	tkl_out_t                  res;
	logic                      accept;
	logic                      walk_end;
	logic                      load_out;
	logic [DOC_BITS+DOC_W-1:0] rd_doc_ext;
	logic [DOC_BITS+DOC_W-1:0] drop_doc_ext;

	assign accept   = s_tvalid && s_tready;
	assign walk_end = (state_q == ST_WALK) && (cnt_q == CNT_W'(LIST_SIZE));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (mode == MODE_READ) ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_WALK: ;
			ST_DONE: load_out = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			inj_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			inj_q   <= accept && (mode == MODE_UPDATE);
			if (state_q == ST_WALK) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q      <= mode;
			slot_q      <= in_slot;
			present_q   <= hit_any;
			inj_doc_q   <= in_doc;
			inj_score_q <= in_score;
		end
		// the carry leaving the last cell is the entry that fell off
		if (walk_end) begin
			drop_v_q   <= last_valid;
			drop_doc_q <= last_doc;
		end
		if (load_out) begin
			m_tdata_q <= res;
		end
	end

	assign rd_doc_ext   = {{DOC_W{1'b0}}, rd_doc};
	assign drop_doc_ext = {{DOC_W{1'b0}}, drop_doc_q};

	always_comb begin
		res = '0;
		if (mode_q == MODE_READ) begin
			res.slot_valid = rd_valid;
			res.slot_doc   = rd_valid ? rd_doc_ext[DOC_W-1:0] : '0;
			res.slot_score = rd_valid ? rd_score : '0;
		end else begin
			res.was_present   = present_q;
			res.dropped_valid = drop_v_q;
			res.dropped_doc   = drop_v_q ? drop_doc_ext[DOC_W-1:0] : '0;
		end
	end

	assign walk_ctl.match_en = accept && (mode == MODE_UPDATE);
	assign walk_ctl.inject   = inj_q;
	assign inj_doc           = inj_doc_q;
	assign inj_score         = inj_score_q;
	assign slot_sel          = slot_q;
	assign m_tvalid          = m_tvalid_q;
	assign m_tdata           = m_tdata_q;
endmodule
`default_nettype wire

>>> rtl/topk_score_list_update.sv
// top-k score list: an update result is loaded once the walk ends, the carried entry
// moving one cell per cycle down the row; a read goes from accept straight to ST_DONE;
// one item is in work at a time; the next is accepted the cycle after its result
// is loaded; an earlier result held back by m_tready delays that load and so the accept;
// arst_n clears all slot valid bits, the sequencer and result valid; depends on tkl_pkg,
// tkl_cell, tkl_ctrl and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module topk_score_list_update #(
	parameter int LIST_SIZE = tkl_pkg::LIST_SIZE_DEF,
	parameter int DOC_BITS  = tkl_pkg::DOC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// doc_id[15:0], score[47:16], slot[51:48], zero pad[55:52]
	input  wire logic [tkl_pkg::IN_W-1:0]     s_tdata,
	// mode[0]
	input  wire logic                         s_tuser,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// slot_valid[0], slot_doc[16:1], slot_score[48:17], was_present[49],
	// dropped_valid[50], dropped_doc[66:51], zero pad[71:67]
	output logic [tkl_pkg::OUT_W-1:0]         m_tdata
);
	import tkl_pkg::*;

	localparam int IDX_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

	tkl_in_t                   in_item;
	tkl_walk_ctl_t             walk_ctl;
	logic [DOC_BITS+DOC_W-1:0] in_doc_ext;
	logic [DOC_BITS-1:0]       in_doc;
	logic [DOC_BITS-1:0]       inj_doc;
	logic signed [SCORE_W-1:0] inj_score;

	logic [LIST_SIZE:0]        carry_valid;
	logic [DOC_BITS-1:0]       carry_doc   [LIST_SIZE+1];
	logic signed [SCORE_W-1:0] carry_score [LIST_SIZE+1];
	logic [LIST_SIZE-1:0]      hit_vec;
	logic [LIST_SIZE-1:0]      ent_valid;
	logic [DOC_BITS-1:0]       ent_doc     [LIST_SIZE];
	logic signed [SCORE_W-1:0] ent_score   [LIST_SIZE];

	logic [SLOT_W-1:0]         slot_sel;
	logic [7:0]                slot_ext;
	logic [IDX_W-1:0]          rd_idx;
	logic                      rd_valid;
	logic [DOC_BITS-1:0]       rd_doc;
	logic signed [SCORE_W-1:0] rd_score;

	assign in_item    = s_tdata;
	assign in_doc_ext = {{DOC_BITS{1'b0}}, in_item.doc_id};
	assign in_doc     = in_doc_ext[DOC_BITS-1:0];

	assign carry_valid[0] = walk_ctl.inject;
	assign carry_doc[0]   = inj_doc;
	assign carry_score[0] = inj_score;

	for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
		tkl_cell #(
			.DOC_BITS(DOC_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.match_en       (walk_ctl.match_en),
			.match_doc      (in_doc),
			.carry_in_valid (carry_valid[i]),
			.carry_in_doc   (carry_doc[i]),
			.carry_in_score (carry_score[i]),
			.carry_out_valid(carry_valid[i+1]),
			.carry_out_doc  (carry_doc[i+1]),
			.carry_out_score(carry_score[i+1]),
			.hit            (hit_vec[i]),
			.entry_valid    (ent_valid[i]),
			.entry_doc      (ent_doc[i]),
			.entry_score    (ent_score[i])
		);
	end

	// slot read; slots past the end of the list read as empty
	assign slot_ext = {4'b0000, slot_sel};
	assign rd_idx   = slot_ext[IDX_W-1:0];

	always_comb begin
		rd_valid = 1'b0;
		rd_doc   = '0;
		rd_score = '0;
		if (slot_ext < 8'(LIST_SIZE)) begin
			rd_valid = ent_valid[rd_idx];
			rd_doc   = ent_doc[rd_idx];
			rd_score = ent_score[rd_idx];
		end
	end

	tkl_ctrl #(
		.LIST_SIZE(LIST_SIZE),
		.DOC_BITS (DOC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.mode      (s_tuser),
		.in_doc    (in_doc),
		.in_score  (in_item.score),
		.in_slot   (in_item.slot),
		.walk_ctl  (walk_ctl),
		.inj_doc   (inj_doc),
		.inj_score (inj_score),
		.hit_any   (|hit_vec),
		.slot_sel  (slot_sel),
		.rd_valid  (rd_valid),
		.rd_doc    (rd_doc),
		.rd_score  (rd_score),
		.last_valid(carry_valid[LIST_SIZE]),
		.last_doc  (carry_doc[LIST_SIZE]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// a document sits in at most one slot
	`ASSERT_ALWAYS(a_single_hit, clk, arst_n, $onehot0(hit_vec))
	// only one carried entry moves down the row at a time
	`ASSERT_ALWAYS(a_single_carry, clk, arst_n, $onehot0(carry_valid))
	// no carried entry is left in the row once new items are taken
	`ASSERT_IMPLY(a_idle_row_empty, clk, arst_n, s_tready, carry_valid == '0)
	// a walk only starts right after an update item was accepted
	`ASSERT_IMPLY(a_inject_after_accept, clk, arst_n, walk_ctl.inject,
		$past(s_tvalid && s_tready && !s_tuser))
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// self-checking bench for topk_score_list_update: directed rows, then random updates and reads
// depends on tkl_pkg and the top-k score list rtl
`timescale 1ns / 1ps
module tb;
	import tkl_pkg::*;

	localparam int LIST_SIZE = LIST_SIZE_DEF;
	localparam int DOC_BITS  = DOC_BITS_DEF;
	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 300;
	localparam logic [DOC_W-1:0] DOC_MASK = {DOC_W{1'b1}} >> (DOC_W - DOC_BITS);
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	typedef struct {
		logic op;
		logic [DOC_W-1:0] doc;
		logic signed [SCORE_W-1:0] sc;
		logic [SLOT_W-1:0] idx;
		bit typed;
		tkl_out_t want;
	} plan_row_t;

	// mirror of the list contents
	logic [DOC_W-1:0] held_doc [LIST_SIZE];
	logic signed [SCORE_W-1:0] held_score [LIST_SIZE];
	bit held_valid [LIST_SIZE];

	tkl_out_t pending_results [$];
	plan_row_t plan_rows [$];
	int fail_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	topk_score_list_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	function automatic tkl_out_t apply_to_list(logic op, logic [DOC_W-1:0] doc,
			logic signed [SCORE_W-1:0] sc, logic [SLOT_W-1:0] idx);
		tkl_out_t res;
		logic [DOC_W-1:0] c_doc;
		logic [DOC_W-1:0] t_doc;
		logic signed [SCORE_W-1:0] c_score;
		logic signed [SCORE_W-1:0] t_score;
		bit done;
		int i;
		res = '0;
		if (op == MODE_READ) begin
			if (int'(idx) < LIST_SIZE && held_valid[idx]) begin
				res.slot_valid = 1'b1;
				res.slot_doc = held_doc[idx];
				res.slot_score = held_score[idx];
			end
		end else begin
			c_doc = doc & DOC_MASK;
			c_score = sc;
			done = 1'b0;
			// drop the old copy of this document first
			for (i = 0; i < LIST_SIZE; i++) begin
				if (!done && held_valid[i] && held_doc[i] == c_doc) begin
					held_valid[i] = 1'b0;
					res.was_present = 1'b1;
					done = 1'b1;
				end
			end
			done = 1'b0;
			for (i = 0; i < LIST_SIZE; i++) begin
				if (!done) begin
					if (!held_valid[i]) begin
						held_valid[i] = 1'b1;
						held_doc[i] = c_doc;
						held_score[i] = c_score;
						done = 1'b1;
					end else if (held_score[i] < c_score) begin
						t_doc = held_doc[i];
						t_score = held_score[i];
						held_doc[i] = c_doc;
						held_score[i] = c_score;
						c_doc = t_doc;
						c_score = t_score;
					end
				end
			end
			if (!done) begin
				res.dropped_valid = 1'b1;
				res.dropped_doc = c_doc;
			end
		end
		return res;
	endfunction

	function automatic tkl_out_t make_want(logic sv, logic [DOC_W-1:0] sd,
			logic signed [SCORE_W-1:0] ss, logic wp, logic dv, logic [DOC_W-1:0] dd);
		tkl_out_t w;
		w = '0;
		w.slot_valid = sv;
		w.slot_doc = sd;
		w.slot_score = ss;
		w.was_present = wp;
		w.dropped_valid = dv;
		w.dropped_doc = dd;
		return w;
	endfunction

	task automatic add_row(logic op, logic [DOC_W-1:0] doc, logic signed [SCORE_W-1:0] sc,
			logic [SLOT_W-1:0] idx, bit typed, tkl_out_t want);
		plan_row_t r;
		r.op = op;
		r.doc = doc;
		r.sc = sc;
		r.idx = idx;
		r.typed = typed;
		r.want = want;
		plan_rows.push_back(r);
	endtask

	// present one item after an idle gap and wait for it to be taken
	task automatic offer_item(logic op, logic [DOC_W-1:0] doc, logic signed [SCORE_W-1:0] sc,
			logic [SLOT_W-1:0] idx, int gap);
		tkl_in_t word;
		word = '0;
		word.doc_id = doc;
		word.score = sc;
		word.slot = idx;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic check_result(tkl_out_t got);
		tkl_out_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result item: %h", got);
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			if (got.slot_valid !== want.slot_valid) begin
				$error("slot_valid: expected %0d, got %0d", want.slot_valid, got.slot_valid);
				fail_count++;
			end
			if (got.slot_doc !== want.slot_doc) begin
				$error("slot_doc: expected %h, got %h", want.slot_doc, got.slot_doc);
				fail_count++;
			end
			if (got.slot_score !== want.slot_score) begin
				$error("slot_score: expected %0d, got %0d", want.slot_score, got.slot_score);
				fail_count++;
			end
			if (got.was_present !== want.was_present) begin
				$error("was_present: expected %0d, got %0d", want.was_present, got.was_present);
				fail_count++;
			end
			if (got.dropped_valid !== want.dropped_valid) begin
				$error("dropped_valid: expected %0d, got %0d", want.dropped_valid,
					got.dropped_valid);
				fail_count++;
			end
			if (got.dropped_doc !== want.dropped_doc) begin
				$error("dropped_doc: expected %h, got %h", want.dropped_doc, got.dropped_doc);
				fail_count++;
			end
		end
	endtask

	// result side: random ready gaps, one long hold-off partway through
	initial begin
		int gap;
		bit burst;
		burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (results_seen == 500) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = burst ? 0 : $urandom_range(0, 18);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_result(tkl_out_t'(m_tdata));
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		tkl_out_t none;
		tkl_out_t res;
		plan_row_t r;
		logic op;
		logic [DOC_W-1:0] doc;
		logic [DOC_W-1:0] pool_mask;
		logic signed [SCORE_W-1:0] sc;
		logic [SLOT_W-1:0] idx;
		bit burst;
		int n;

		none = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list after reset
		add_row(MODE_READ, 16'h0000, 0, 4'd0, 1, none);
		add_row(MODE_READ, 16'hFFFF, SCORE_MAX, 4'd15, 1, none);
		add_row(MODE_UPDATE, 16'hFFFF, SCORE_MAX, 4'd0, 1, none);
		add_row(MODE_READ, 16'h0000, 0, 4'd0, 1, make_want(1, 16'hFFFF, SCORE_MAX, 0, 0, 0));
		add_row(MODE_UPDATE, 16'h0000, SCORE_MIN, 4'hF, 1, none);
		// same document again: reported as already held
		add_row(MODE_UPDATE, 16'hFFFF, SCORE_MIN, 4'd0, 1, make_want(0, 0, 0, 1, 0, 0));
		add_row(MODE_READ, 16'h0000, 0, 4'd0, 0, none);
		add_row(MODE_READ, 16'h0000, 0, 4'd1, 0, none);
		// equal scores keep the earlier entry above
		add_row(MODE_UPDATE, 16'h0005, 0, 4'd0, 0, none);
		add_row(MODE_UPDATE, 16'h0006, 0, 4'd0, 0, none);
		add_row(MODE_READ, 16'h0000, 0, 4'd2, 0, none);
		add_row(MODE_READ, 16'h0000, 0, 4'd3, 0, none);
		for (n = 0; n < 12; n++)
			add_row(MODE_UPDATE, 16'(16 + n), 32'(n * 1000 - 5000), 4'd0, 0, none);
		// full list, new entry beats nothing: it drops itself
		add_row(MODE_UPDATE, 16'h1234, SCORE_MIN, 4'd0, 1, make_want(0, 0, 0, 0, 1, 16'h1234));
		add_row(MODE_UPDATE, 16'h8001, SCORE_MAX, 4'd0, 0, none);
		add_row(MODE_READ, 16'h0000, 0, 4'd15, 0, none);

		foreach (plan_rows[i]) begin
			r = plan_rows[i];
			offer_item(r.op, r.doc, r.sc, r.idx, $urandom_range(0, 18));
			res = apply_to_list(r.op, r.doc, r.sc, r.idx);
			pending_results.push_back(r.typed ? r.want : res);
		end

		burst = 1'b0;
		pool_mask = '0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (n % 300 == 0)
				pool_mask = 16'($urandom);
			// let the block drain completely once
			if (n == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			op = ($urandom_range(0, 99) < 55) ? MODE_UPDATE : MODE_READ;
			// mostly a small pool of documents so they recur while held
			if ($urandom_range(0, 99) < 80)
				doc = 16'($urandom_range(0, 23)) ^ pool_mask;
			else
				doc = 16'($urandom);
			case ($urandom_range(0, 9))
				0: sc = SCORE_MIN;
				1: sc = SCORE_MAX;
				2, 3, 4: sc = 32'($signed($urandom_range(0, 16)) - 8);
				default: sc = 32'($urandom);
			endcase
			idx = 4'($urandom_range(0, 15));
			offer_item(op, doc, sc, idx, burst ? 0 : $urandom_range(0, 18));
			pending_results.push_back(apply_to_list(op, doc, sc, idx));
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (LIST_SIZE + 8) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
